### rtl/core/fea_pkg.sv
package fea_pkg;

  localparam int NUM_MATERIALS = 16;
  localparam int MAX_EXTENT    = 1023;

  localparam int MAT_ID_W  = 4;
  localparam int MAT_AW    = $clog2(NUM_MATERIALS);
  localparam int GRID_W    = 10;
  localparam int COORD_W   = $clog2(MAX_EXTENT + 2);
  localparam int NUM_COMP  = 6;
  localparam int COMP_W    = 3;
  localparam int COEF_W    = 16;
  localparam int VAL_W     = 16;
  localparam int SQ_W      = 2 * VAL_W;
  localparam int PROD_W    = COEF_W + SQ_W;
  localparam int TERM_W    = PROD_W + 2;
  localparam int SUM_W     = 63;
  localparam int CFG_IDX_W = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [COMP_W-1:0] LAST_COMP = COMP_W'(NUM_COMP - 1);

  typedef enum logic {
    FUNC_NODE  = 1'b0,
    FUNC_TABLE = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_NX = 2'd0,
    CFG_GRID_NY = 2'd1,
    CFG_GRID_NZ = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_SQUARE,
    S_MULT,
    S_ACCUM,
    S_FINISH
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [6:0]         table_addr;
    logic [15:0]        table_value;
    logic signed [15:0] e_x;
    logic signed [15:0] e_y;
    logic signed [15:0] e_z;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic [11:0]        e_material_ids;
    logic [11:0]        b_material_ids;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0] energy_ex;
    logic [SUM_W-1:0] energy_ey;
    logic [SUM_W-1:0] energy_ez;
    logic [SUM_W-1:0] energy_bx;
    logic [SUM_W-1:0] energy_by;
    logic [SUM_W-1:0] energy_bz;
  } result_t;

  typedef struct packed {
    logic              capture;
    logic              table_write;
    logic              square;
    logic              mult;
    logic              accum;
    logic              advance;
    logic              emit;
    logic [COMP_W-1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic last_node;
  } status_t;

endpackage

### rtl/core/fea_ram.sv
module fea_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/fea_datapath.sv
module fea_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [fea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fea_pkg::GRID_W-1:0]    cfg_data,
  input  fea_pkg::item_t                item,
  input  fea_pkg::cmd_t                 cmd,
  output fea_pkg::status_t              stat,
  output fea_pkg::result_t              result
);

  import fea_pkg::*;

  item_t              word;
  logic [GRID_W-1:0]  grid_nx;
  logic [GRID_W-1:0]  grid_ny;
  logic [GRID_W-1:0]  grid_nz;
  logic [COORD_W-1:0] nx;
  logic [COORD_W-1:0] ny;
  logic [COORD_W-1:0] nz;
  logic [COORD_W-1:0] node_x;
  logic [COORD_W-1:0] node_y;
  logic [COORD_W-1:0] node_z;
  logic               end_x;
  logic               end_y;
  logic               end_z;

  logic [NUM_MATERIALS-1:0] valid [NUM_COMP];
  logic [COEF_W-1:0]        coef_rd [NUM_COMP];
  logic [NUM_COMP-1:0]      valid_rd;
  logic [MAT_ID_W-1:0]      wr_id;
  logic [2:0]               wr_col;
  logic                     wr_ok;

  logic [SUM_W-1:0]  sums [NUM_COMP];
  logic [SQ_W-1:0]   sq;
  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  raw;
  logic [VAL_W-1:0]  mag;
  logic [COEF_W-1:0] coef;
  logic              in_x, in_y, in_z;
  logic [1:0]        sh_x, sh_y, sh_z;
  logic [2:0]        q;
  logic [TERM_W-1:0] term;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;

  function automatic logic [COORD_W-1:0] extent(input logic [GRID_W-1:0] r);
    logic [COORD_W-1:0] e;
    if (r == '0) begin
      e = COORD_W'(1);
    end else if (32'(r) > MAX_EXTENT) begin
      e = COORD_W'(MAX_EXTENT);
    end else begin
      e = COORD_W'(r);
    end
    return e;
  endfunction

  function automatic logic [1:0] share(input logic [COORD_W-1:0] c,
                                       input logic [COORD_W-1:0] n);
    logic [1:0] k;
    k = 2'd0;
    if (c >= COORD_W'(1) && c <= n) begin
      k = k + 2'd1;
    end
    if (c >= COORD_W'(2) && (c - COORD_W'(1)) <= n) begin
      k = k + 2'd1;
    end
    return k;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_nx <= GRID_W'(1);
      grid_ny <= GRID_W'(1);
      grid_nz <= GRID_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GRID_NX: grid_nx <= cfg_data;
        CFG_GRID_NY: grid_ny <= cfg_data;
        CFG_GRID_NZ: grid_nz <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nx = extent(grid_nx);
  assign ny = extent(grid_ny);
  assign nz = extent(grid_nz);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word <= item;
    end
  end

  // material table, one ram per column
  assign wr_id  = word.table_addr[6:3];
  assign wr_col = word.table_addr[2:0];
  assign wr_ok  = 32'(wr_id) < NUM_MATERIALS;

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_col
    localparam int AXIS = c % 3;
    logic [MAT_ID_W-1:0] rd_id;
    logic                we;

    assign rd_id = (c < 3) ? word.e_material_ids[MAT_ID_W*AXIS +: MAT_ID_W]
                           : word.b_material_ids[MAT_ID_W*AXIS +: MAT_ID_W];
    assign we = cmd.table_write && wr_ok && (wr_col == 3'(c));

    fea_ram #(
      .WIDTH (COEF_W),
      .DEPTH (NUM_MATERIALS)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (MAT_AW'(wr_id)),
      .wdata (word.table_value),
      .raddr (MAT_AW'(rd_id)),
      .rdata (coef_rd[c])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[c] <= '0;
      end else if (we) begin
        valid[c][MAT_AW'(wr_id)] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      valid_rd[c] <= (32'(rd_id) < NUM_MATERIALS) && valid[c][MAT_AW'(rd_id)];
    end
  end

  // node position
  assign end_x = node_x >= nx + COORD_W'(1);
  assign end_y = node_y >= ny + COORD_W'(1);
  assign end_z = node_z >= nz + COORD_W'(1);
  assign stat.last_node = end_x && end_y && end_z;

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      node_x <= COORD_W'(1);
      node_y <= COORD_W'(1);
      node_z <= COORD_W'(1);
    end else if (cmd.advance) begin
      if (end_x) begin
        node_x <= COORD_W'(1);
        if (end_y) begin
          node_y <= COORD_W'(1);
          node_z <= node_z + COORD_W'(1);
        end else begin
          node_y <= node_y + COORD_W'(1);
        end
      end else begin
        node_x <= node_x + COORD_W'(1);
      end
    end
  end

  // shared square and coefficient multiply
  always_comb begin
    unique case (cmd.comp)
      3'd0:    raw = word.e_x;
      3'd1:    raw = word.e_y;
      3'd2:    raw = word.e_z;
      3'd3:    raw = word.b_x;
      3'd4:    raw = word.b_y;
      3'd5:    raw = word.b_z;
      default: raw = '0;
    endcase
    mag = raw[VAL_W-1] ? (~raw + VAL_W'(1)) : raw;
    coef = (cmd.comp < COMP_W'(NUM_COMP) && valid_rd[cmd.comp]) ? coef_rd[cmd.comp] : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq <= mag * mag;
    end
    if (cmd.mult) begin
      prod <= coef * sq;
    end
  end

  // neighbour weight
  assign in_x = (node_x >= COORD_W'(1)) && (node_x <= nx);
  assign in_y = (node_y >= COORD_W'(1)) && (node_y <= ny);
  assign in_z = (node_z >= COORD_W'(1)) && (node_z <= nz);
  assign sh_x = share(node_x, nx);
  assign sh_y = share(node_y, ny);
  assign sh_z = share(node_z, nz);

  always_comb begin
    unique case (cmd.comp)
      3'd0:    q = in_x ? 3'(sh_y) * 3'(sh_z) : 3'd0;
      3'd1:    q = in_y ? 3'(sh_z) * 3'(sh_x) : 3'd0;
      3'd2:    q = in_z ? 3'(sh_x) * 3'(sh_y) : 3'd0;
      3'd3:    q = (in_y && in_z) ? {sh_x, 1'b0} : 3'd0;
      3'd4:    q = (in_z && in_x) ? {sh_y, 1'b0} : 3'd0;
      3'd5:    q = (in_x && in_y) ? {sh_z, 1'b0} : 3'd0;
      default: q = 3'd0;
    endcase
    unique case (q)
      3'd1:    term = TERM_W'(prod);
      3'd2:    term = TERM_W'({prod, 1'b0});
      3'd4:    term = {prod, 2'b00};
      default: term = '0;
    endcase
    sum_ext = {1'b0, sums[cmd.comp]} + (SUM_W + 1)'(term);
    sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        sums[i] <= '0;
      end
    end else if (cmd.accum) begin
      sums[cmd.comp] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.energy_ex <= sums[0];
      result.energy_ey <= sums[1];
      result.energy_ez <= sums[2];
      result.energy_bx <= sums[3];
      result.energy_by <= sums[4];
      result.energy_bz <= sums[5];
    end
  end

endmodule

### rtl/core/fea_controller.sv
module fea_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  fea_pkg::func_t   item_func,
  output logic             item_stall,
  output logic             result_valid,
  input  logic             result_stall,
  input  fea_pkg::status_t stat,
  output fea_pkg::cmd_t    cmd
);

  import fea_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [COMP_W-1:0] comp;
  logic [COMP_W-1:0] comp_next;
  logic              result_valid_next;
  logic              out_free;

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      comp         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      comp         <= comp_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next        = state;
    comp_next         = comp;
    result_valid_next = result_valid && result_stall;
    item_stall        = 1'b1;
    cmd               = '0;
    cmd.comp          = comp;
    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = (item_func == FUNC_TABLE) ? S_WRITE : S_READ;
        end
      end
      S_WRITE: begin
        cmd.table_write = 1'b1;
        state_next      = S_IDLE;
      end
      S_READ: begin
        comp_next  = '0;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        if (comp == LAST_COMP) begin
          state_next = S_FINISH;
        end else begin
          comp_next  = comp + COMP_W'(1);
          state_next = S_SQUARE;
        end
      end
      S_FINISH: begin
        if (!stat.last_node) begin
          cmd.advance = 1'b1;
          state_next  = S_IDLE;
        end else if (out_free) begin
          cmd.emit          = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/core/field_energy_accumulator.sv
// field energy accumulator
// item channel (item_valid / item_stall / item): one word is either a
// material table write (func = table) or one grid node sample. nodes come in
// raster order, x fastest, over (nx+1)(ny+1)(nz+1) nodes per pass.
// result channel (result_valid / result_stall / result): one word with the
// six saturated energy sums, sent after the last node of a pass; the sums
// and node position then start over.
// cfg port: grid_nx, grid_ny, grid_nz at index 0..2, zero counting as one; the
// user writes them with cfg_write only while the block is idle (not enforced).
// steps: a table write passes the idle and write states; a node passes the read
// state (material ram read), then square, multiply and accumulate for each of the
// six field components, which share one squarer and one coefficient multiplier,
// then finish; at the last node, finish registers the result word and valid.
// a waiting result is held in the output register while new items are taken;
// if a pass ends while the receiver still stalls the previous result, the
// block holds item_stall high until that result is taken.
// reset (rst, synchronous): material table reads as zero, sums cleared,
// position at the first node, grid counts one, no result pending.
module field_energy_accumulator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  fea_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output fea_pkg::result_t              result,
  input  logic                          cfg_write,
  input  logic [fea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fea_pkg::GRID_W-1:0]    cfg_data
);

  import fea_pkg::*;

  cmd_t    cmd;
  status_t stat;

  fea_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_func    (item.func),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  fea_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

### rtl/core/fea_checker.sv
module fea_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input fea_pkg::result_t result
);

  // a held result word does not change
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  // after taking a word the block stalls the item channel
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item taken on consecutive cycles");

  // results come out only at the end of node processing
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared while idle");

endmodule

bind field_energy_accumulator fea_checker u_fea_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

### bench/field_energy_accumulator_tb.sv
`timescale 1ns / 100ps

module field_energy_accumulator_tb;
  import fea_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES = 900;
  localparam result_t PEAK_SUMS = {6{63'h0000_ffff_0000_0000}};

  typedef enum logic [2:0] {
    COL_EPS_X, COL_EPS_Y, COL_EPS_Z, COL_RMU_X, COL_RMU_Y, COL_RMU_Z,
    COL_UNUSED6, COL_UNUSED7
  } col_t;

  typedef struct {
    item_t   w;
    bit      typed;
    result_t lit;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_NX;
  logic [GRID_W-1:0] cfg_data = '0;

  bit row_typed = 1'b0;
  result_t row_lit = '0;
  bit calm = 1'b0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int mismatches = 0;

  // predictor state
  logic [15:0] coef_tab [NUM_MATERIALS*6] = '{default: '0};
  logic [SUM_W-1:0] sums [NUM_COMP] = '{default: '0};
  int unsigned pos_x = 1, pos_y = 1, pos_z = 1;
  logic [GRID_W-1:0] set_nx = GRID_W'(1), set_ny = GRID_W'(1), set_nz = GRID_W'(1);
  result_t pending_sums [$];
  string sum_names [NUM_COMP] = '{"energy_ex", "energy_ey", "energy_ez",
                                  "energy_bx", "energy_by", "energy_bz"};
  dir_row_t dir_rows [25];

  field_energy_accumulator DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned grid_extent(input logic [GRID_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_EXTENT) return MAX_EXTENT;
    return 32'(r);
  endfunction

  // voxels in 1..n among {c-1, c}
  function automatic int unsigned span(input int unsigned c, input int unsigned n);
    int unsigned k;
    k = 0;
    if (c >= 1 && c <= n) k++;
    if (c >= 2 && c - 1 <= n) k++;
    return k;
  endfunction

  function automatic int unsigned on_grid(input int unsigned c, input int unsigned n);
    return (c >= 1 && c <= n) ? 1 : 0;
  endfunction

  function automatic logic [31:0] mag_sq(input logic [15:0] v);
    logic [16:0] m;
    m = v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
    return 32'(m) * 32'(m);
  endfunction

  function automatic void step_energy(input item_t w, output bit fin, output result_t r);
    int unsigned nx, ny, nz, ix, iy, iz, sx, sy, sz;
    logic [63:0] q [NUM_COMP];
    logic [15:0] vals [NUM_COMP];
    logic [11:0] ids;
    logic [3:0] mid;
    logic [63:0] c, term, room;
    fin = 1'b0;
    r = '0;
    if (w.func == FUNC_TABLE) begin
      mid = w.table_addr[6:3];
      if (w.table_addr[2:0] <= COL_RMU_Z && mid < NUM_MATERIALS)
        coef_tab[mid * 6 + w.table_addr[2:0]] = w.table_value;
      return;
    end
    nx = grid_extent(set_nx);
    ny = grid_extent(set_ny);
    nz = grid_extent(set_nz);
    ix = on_grid(pos_x, nx);
    iy = on_grid(pos_y, ny);
    iz = on_grid(pos_z, nz);
    sx = span(pos_x, nx);
    sy = span(pos_y, ny);
    sz = span(pos_z, nz);
    q[0] = 64'(ix * sy * sz);
    q[1] = 64'(iy * sz * sx);
    q[2] = 64'(iz * sx * sy);
    q[3] = 64'(2 * sx * iy * iz);
    q[4] = 64'(2 * sy * iz * ix);
    q[5] = 64'(2 * sz * ix * iy);
    vals = '{w.e_x, w.e_y, w.e_z, w.b_x, w.b_y, w.b_z};
    for (int k = 0; k < NUM_COMP; k++) begin
      ids = (k < 3) ? w.e_material_ids : w.b_material_ids;
      mid = ids[4*(k%3) +: 4];
      c = (mid < NUM_MATERIALS) ? 64'(coef_tab[mid * 6 + k]) : 64'd0;
      term = c * 64'(mag_sq(vals[k])) * q[k];
      room = 64'(SUM_MAX) - 64'(sums[k]);
      sums[k] = (term > room) ? SUM_MAX : sums[k] + SUM_W'(term);
    end
    if (pos_x >= nx + 1 && pos_y >= ny + 1 && pos_z >= nz + 1) begin
      fin = 1'b1;
      r.energy_ex = sums[0];
      r.energy_ey = sums[1];
      r.energy_ez = sums[2];
      r.energy_bx = sums[3];
      r.energy_by = sums[4];
      r.energy_bz = sums[5];
      for (int k = 0; k < NUM_COMP; k++) sums[k] = '0;
      pos_x = 1;
      pos_y = 1;
      pos_z = 1;
      return;
    end
    if (pos_x >= nx + 1) begin
      pos_x = 1;
      if (pos_y >= ny + 1) begin
        pos_y = 1;
        pos_z++;
      end else begin
        pos_y++;
      end
    end else begin
      pos_x++;
    end
  endfunction

  function automatic item_t node_word(input logic [95:0] vals, input logic [23:0] ids);
    item_t w;
    w = '0;
    w.func = FUNC_NODE;
    {w.e_x, w.e_y, w.e_z, w.b_x, w.b_y, w.b_z} = vals;
    {w.e_material_ids, w.b_material_ids} = ids;
    return w;
  endfunction

  function automatic item_t table_word(input logic [3:0] mat, input col_t col,
                                       input logic [15:0] val);
    item_t w;
    w = '0;
    w.func = FUNC_TABLE;
    w.table_addr = {mat, col};
    w.table_value = val;
    return w;
  endfunction

  function automatic logic [15:0] rand_half();
    logic [15:0] corner_vals [5] = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h0001};
    return ($urandom_range(7) == 0) ? corner_vals[$urandom_range(4)] : 16'($urandom);
  endfunction

  function automatic item_t random_word(input bit node_only);
    item_t w;
    w.func = (!node_only && $urandom_range(99) < 15) ? FUNC_TABLE : FUNC_NODE;
    w.table_addr = 7'($urandom_range(127));
    w.table_value = rand_half();
    w.e_x = rand_half();
    w.e_y = rand_half();
    w.e_z = rand_half();
    w.b_x = rand_half();
    w.b_y = rand_half();
    w.b_z = rand_half();
    w.e_material_ids = 12'($urandom_range(4095));
    w.b_material_ids = 12'($urandom_range(4095));
    return w;
  endfunction

  function automatic logic [GRID_W-1:0] pick_extent();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return GRID_W'(MAX_EXTENT);
    return GRID_W'($urandom_range(1, 3));
  endfunction

  task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                 input logic [SUM_W-1:0] want);
    if (mismatches < 50)
      $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(input item_t w, input bit typed, input result_t lit);
    int gap;
    gap = (!calm && $urandom_range(99) < 22) ? $urandom_range(1, 24) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    row_typed <= typed;
    row_lit <= lit;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic drain_and_wait();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_grid(input logic [GRID_W-1:0] gx, gy, gz);
    logic [GRID_W-1:0] v [3];
    cfg_reg_t regs [3];
    v = '{gx, gy, gz};
    regs = '{CFG_GRID_NX, CFG_GRID_NY, CFG_GRID_NZ};
    for (int a = 0; a < 3; a++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[a];
      cfg_data <= v[a];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 22);
    end
  end

  always @(posedge clk) begin
    bit fin;
    result_t fresh, want;
    logic [SUM_W-1:0] got_v [NUM_COMP], want_v [NUM_COMP];
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_GRID_NX: set_nx = cfg_data;
          CFG_GRID_NY: set_ny = cfg_data;
          CFG_GRID_NZ: set_nz = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        step_energy(item, fin, fresh);
        if (fin) pending_sums.push_back(row_typed ? row_lit : fresh);
      end
      if (result_valid && !result_stall) begin
        if (pending_sums.size() == 0) begin
          report_mismatch("unexpected result word", result.energy_ex, '0);
        end else begin
          want = pending_sums.pop_front();
          got_v = '{result.energy_ex, result.energy_ey, result.energy_ez,
                    result.energy_bx, result.energy_by, result.energy_bz};
          want_v = '{want.energy_ex, want.energy_ey, want.energy_ez,
                     want.energy_bx, want.energy_by, want.energy_bz};
          for (int k = 0; k < NUM_COMP; k++)
            if (got_v[k] !== want_v[k]) report_mismatch(sum_names[k], got_v[k], want_v[k]);
        end
      end
    end
  end

  initial begin
    int phase, count, words_sent;
    bit quiet;
    logic [GRID_W-1:0] gx, gy, gz;

    // first pass on a 1x1x1 grid with an empty table: all sums zero
    dir_rows[0]  = '{node_word({6{16'h8000}}, {2{12'hfff}}), 1'b0, '0};
    dir_rows[1]  = '{node_word({6{16'h7fff}}, {2{12'h000}}), 1'b0, '0};
    dir_rows[2]  = '{node_word({6{16'hffff}}, {2{12'h000}}), 1'b0, '0};
    dir_rows[3]  = '{node_word({6{16'h0000}}, {2{12'hfff}}), 1'b0, '0};
    dir_rows[4]  = '{node_word({6{16'h0001}}, {2{12'h5a5}}), 1'b0, '0};
    dir_rows[5]  = '{node_word({16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5a5a},
                               {12'habc, 12'h123}), 1'b0, '0};
    dir_rows[6]  = '{node_word({6{16'h7fff}}, {2{12'hfff}}), 1'b0, '0};
    dir_rows[7]  = '{node_word({6{16'h8000}}, {2{12'hfff}}), 1'b1, '0};
    dir_rows[8]  = '{table_word(4'hf, COL_EPS_X, 16'hffff), 1'b0, '0};
    dir_rows[9]  = '{table_word(4'hf, COL_EPS_Y, 16'hffff), 1'b0, '0};
    dir_rows[10] = '{table_word(4'hf, COL_EPS_Z, 16'hffff), 1'b0, '0};
    dir_rows[11] = '{table_word(4'hf, COL_RMU_X, 16'hffff), 1'b0, '0};
    dir_rows[12] = '{table_word(4'hf, COL_RMU_Y, 16'hffff), 1'b0, '0};
    dir_rows[13] = '{table_word(4'hf, COL_RMU_Z, 16'hffff), 1'b0, '0};
    dir_rows[14] = '{table_word(4'h0, COL_UNUSED6, 16'hffff), 1'b0, '0};
    dir_rows[15] = '{table_word(4'h0, COL_UNUSED7, 16'hffff), 1'b0, '0};
    dir_rows[16] = '{table_word(4'h0, COL_RMU_X, 16'h0001), 1'b0, '0};
    // second pass at full coefficient and full magnitude
    for (int i = 17; i < 24; i++)
      dir_rows[i] = '{node_word({6{16'h8000}}, {2{12'hfff}}), 1'b0, '0};
    dir_rows[24] = '{node_word({6{16'h8000}}, {2{12'hfff}}), 1'b1, PEAK_SUMS};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 25; i++)
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].lit);

    phase = 0;
    words_sent = 0;
    while (words_sent < 1800) begin
      drain_and_wait();
      quiet = ($urandom_range(5) == 0);
      count = $urandom_range(20, 90);
      case (phase)
        0: begin
          gx = '0; gy = '0; gz = '0;
        end
        1: begin
          gx = GRID_W'(1); gy = GRID_W'(MAX_EXTENT); gz = GRID_W'(1); count = 30;
        end
        2: begin
          gx = GRID_W'(1); gy = GRID_W'(1); gz = GRID_W'(1); quiet = 1'b1; count = 80;
        end
        3: begin
          gx = GRID_W'(2); gy = GRID_W'(1); gz = GRID_W'(MAX_EXTENT); count = 30;
        end
        default: begin
          gx = pick_extent(); gy = pick_extent(); gz = pick_extent();
        end
      endcase
      calm <= quiet;
      // receiver holds off while words keep coming, so the block backs up
      if (phase == 2) hold_ask <= hold_ask + 1;
      load_grid(gx, gy, gz);
      repeat (count) begin
        send_word(random_word(1'b0), 1'b0, '0);
        words_sent++;
      end
      phase++;
    end

    drain_and_wait();
    if (pending_sums.size() != 0) report_mismatch("expected word never arrived", '0, '0);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
